FILE: rtl/core/gf7sec_pkg.sv
// Shared types, constants and GF(7) arithmetic helpers for the GF(7)
// single-error syndrome corrector.
// No dependencies.
package gf7sec_pkg;

	localparam int NumDigits = 7;
	localparam int NumSyn    = 3;
	localparam int InDataW   = 24;
	localparam int OutDataW  = 32;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 21;

	typedef logic [2:0] digit_t;
	typedef digit_t [NumSyn-1:0]    syn_t;
	typedef digit_t [NumDigits-1:0] word_t;

	localparam digit_t DigitMod  = 3'd7;
	localparam digit_t LastCoord = 3'd6;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_FIXED = 2'd1,
		ST_FAIL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SYN,
		SEQ_SEARCH,
		SEQ_FINISH
	} seq_state_t;

	localparam logic [CfgIdxW-1:0] REG_COL_ZERO = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_COL_ONE  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_COL_TWO  = 2'd2;

	typedef struct packed {
		logic   found;
		digit_t amount;
	} hit_t;

	// a raw 3-bit code of 7 counts as 0
	function automatic digit_t red7(input digit_t x);
		return (x == DigitMod) ? 3'd0 : x;
	endfunction

	// operands already reduced (0..6)
	function automatic digit_t add7(input digit_t a, input digit_t b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, DigitMod}) begin
			s = s - {1'b0, DigitMod};
		end
		return s[2:0];
	endfunction

	// 8 = 1 mod 7: fold the high octal digit onto the low one
	function automatic digit_t mul7(input digit_t a, input digit_t b);
		logic [5:0] p;
		logic [3:0] t;
		p = {3'b000, a} * {3'b000, b};
		t = {1'b0, p[5:3]} + {1'b0, p[2:0]};
		if (t >= {1'b0, DigitMod}) begin
			t = t - {1'b0, DigitMod};
		end
		return t[2:0];
	endfunction

endpackage

FILE: rtl/core/gf7_syndrome_single_error_corrector.sv
// Top level of the GF(7) single-error syndrome corrector: sequencer, word and
// syndrome registers, configuration registers and the output register.
// Depends on gf7sec_pkg and gf7sec_unit.

// Each request is a 7-digit word over GF(7). The block forms its 3-digit
// syndrome against the configured check columns one coordinate per cycle,
// then, if the syndrome is nonzero, tries single-digit corrections one
// coordinate per cycle from coordinate 6 down to 0 (all six amounts of a
// coordinate in the same cycle); both steps use the shared GF(7) unit. The
// request is taken into the word register, and the result is loaded into the
// output register once that register is free. s_tready is low while a word is
// in work; a finished result waits in the output register while the next
// word is taken. Input and column digits equal to 7 count as 0. Column
// registers reset to 0.
module gf7_syndrome_single_error_corrector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gf7sec_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [gf7sec_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// digit_zero, digit_one, ... digit_six (3 bits each), 3 zero bits
	input  logic [gf7sec_pkg::InDataW-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// fixed_zero .. fixed_six (3 bits each), status (2), syn_zero, syn_one, syn_two (3 each)
	output logic [gf7sec_pkg::OutDataW-1:0]    m_tdata
);
	import gf7sec_pkg::*;

	seq_state_t state_q, state_d;
	word_t      col_q [NumSyn];
	word_t      y_q;
	syn_t       acc_q;
	digit_t     k_q;
	status_t    status_q;
	logic       out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	syn_t   h;
	syn_t   sum;
	hit_t   hit;
	logic   take;
	logic   load_out;

	always_comb begin
		for (int c = 0; c < NumSyn; c++) begin
			h[c] = red7(col_q[c][k_q]);
		end
	end

	gf7sec_unit u_unit (
		.x   (y_q[k_q]),
		.h   (h),
		.s   (acc_q),
		.sum (sum),
		.hit (hit)
	);

	assign take     = s_tvalid && s_tready;
	assign load_out = (state_q == SEQ_FINISH) && (!out_valid_q || m_tready);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = SEQ_SYN;
				end
			end
			SEQ_SYN: begin
				if (k_q == LastCoord) begin
					state_d = (sum == '0) ? SEQ_FINISH : SEQ_SEARCH;
				end
			end
			SEQ_SEARCH: begin
				if (hit.found || k_q == 3'd0) begin
					state_d = SEQ_FINISH;
				end
			end
			SEQ_FINISH: begin
				if (load_out) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NumSyn; c++) begin
				col_q[c] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COL_ZERO: col_q[0] <= cfg_data;
				REG_COL_ONE:  col_q[1] <= cfg_data;
				REG_COL_TWO:  col_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// word, syndrome, status and coordinate counter
	always_ff @(posedge clk) begin
		case (state_q)
			SEQ_IDLE: begin
				if (take) begin
					for (int i = 0; i < NumDigits; i++) begin
						y_q[i] <= red7(s_tdata[3*i +: 3]);
					end
					acc_q    <= '0;
					k_q      <= '0;
					status_q <= ST_VALID;
				end
			end
			SEQ_SYN: begin
				acc_q <= sum;
				if (k_q == LastCoord) begin
					status_q <= (sum == '0) ? ST_VALID : ST_FAIL;
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
			SEQ_SEARCH: begin
				if (hit.found) begin
					y_q[k_q] <= add7(y_q[k_q], hit.amount);
					status_q <= ST_FIXED;
				end else if (k_q != 3'd0) begin
					k_q <= k_q - 3'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {acc_q, status_q, y_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/core/gf7sec_unit.sv
// Shared GF(7) unit: multiply-accumulate of one coordinate into the syndrome,
// and the trial of all six correction amounts for one coordinate.
// Depends on gf7sec_pkg.
module gf7sec_unit (
	input  gf7sec_pkg::digit_t x,
	input  gf7sec_pkg::syn_t   h,
	input  gf7sec_pkg::syn_t   s,
	output gf7sec_pkg::syn_t   sum,
	output gf7sec_pkg::hit_t   hit
);
	import gf7sec_pkg::*;

	logic [6:1] zero_a;

	always_comb begin
		for (int c = 0; c < NumSyn; c++) begin
			sum[c] = add7(s[c], mul7(x, h[c]));
		end
	end

	always_comb begin
		for (int a = 1; a < 7; a++) begin
			zero_a[a] = 1'b1;
			for (int c = 0; c < NumSyn; c++) begin
				if (add7(s[c], mul7(digit_t'(a), h[c])) != 3'd0) begin
					zero_a[a] = 1'b0;
				end
			end
		end
	end

	// smallest amount wins
	always_comb begin
		hit = '0;
		for (int a = 6; a >= 1; a--) begin
			if (zero_a[a]) begin
				hit.found  = 1'b1;
				hit.amount = digit_t'(a);
			end
		end
	end

endmodule

FILE: rtl/core/gf7sec_checker.sv
// Port-level checks for the GF(7) single-error syndrome corrector, with the
// bind that attaches them to the top level.
// Depends on gf7sec_pkg.
module gf7sec_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [gf7sec_pkg::OutDataW-1:0] m_tdata
);
	import gf7sec_pkg::*;

	logic [1:0] stat;
	logic [8:0] syn;

	assign stat = m_tdata[22:21];
	assign syn  = m_tdata[31:23];

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> stat == ST_VALID || stat == ST_FIXED || stat == ST_FAIL)
		else $error("bad status code");

	a_valid_zero_syn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && stat == ST_VALID |-> syn == 9'd0)
		else $error("valid status with nonzero syndrome");

	a_error_nonzero_syn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (stat == ST_FIXED || stat == ST_FAIL) |-> syn != 9'd0)
		else $error("error status with zero syndrome");

endmodule

bind gf7_syndrome_single_error_corrector gf7sec_checker u_gf7sec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
